// File: hw/rtl/bls_pkg.sv
// Package for the Bresenham line stepper: item and command types, widths, helpers.
// No dependencies; every other file of the block imports it.
package bls_pkg;

  // Coordinate width and derived widths of the decision arithmetic
  localparam int unsigned CoordW = 12;
  localparam int unsigned DecW   = CoordW + 3;  // signed decision term and diagonal increment
  localparam int unsigned IncW   = CoordW + 2;  // unsigned straight increment

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Request codes
  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_e;

  // Input beat
  typedef struct packed {
    req_e              req_type;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } in_item_t;

  // Output beat
  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic              last;
  } out_item_t;

  // Classified command: a step, or a start with its line setup worked out
  typedef struct packed {
    req_e                    req;
    logic                    dir_x_neg;
    logic                    dir_y_neg;
    logic                    x_major;
    logic signed [DecW-1:0]  decision;
    logic signed [DecW-1:0]  inc_diag;
    logic [IncW-1:0]         inc_straight;
    logic [CoordW-1:0]       remaining;
    logic [CoordW-1:0]       cur_x;
    logic [CoordW-1:0]       cur_y;
  } cmd_t;

  // Status of the back end
  typedef struct packed {
    logic busy;
  } back_status_t;

  // One pixel step along an axis, wrapping at the coordinate width
  function automatic logic [CoordW-1:0] move_coord(logic [CoordW-1:0] c, logic neg);
    return neg ? (c - 1'b1) : (c + 1'b1);
  endfunction

endpackage

// File: hw/rtl/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: front end, command queue and back end.
// Depends on bls_pkg, bls_front, bls_cmd_queue and bls_back.

// A start beat loads two endpoints and yields the first endpoint as a pixel; each
// step beat after it yields the next pixel of the line, with last set on the second
// endpoint. A step with no line in progress yields nothing, and a start during a
// line drops it. The block sustains one beat per clock unless the output stalls:
// the front end works out the line setup (deltas, major axis, decision term) as
// the beat enters the two-entry command queue; per pixel, the back end tests the
// decision sign and updates the decision, coordinates and count. A pixel passes the
// queue, then the output register; the input stalls only once the queue is full.
module bresenham_line_stepper
  import bls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  cmd_t         front_cmd, queue_cmd;
  logic         queue_full, queue_valid, queue_pop;
  back_status_t back_status;

  assign in_stall_o = queue_full;

  // Classification and setup
  bls_front u_front (
    .item_i (in_i),
    .cmd_o  (front_cmd)
  );

  // Decoupling queue
  bls_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .cmd_o   (queue_cmd)
  );

  // Line stepping
  bls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .status_o    (back_status)
  );

  // A pixel that is not the last one leaves a line in progress behind it
  a_mid_pixel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> back_status.busy)
    else $error("non-final pixel pending while no line is in progress");

  // The final pixel of a line leaves the back end idle
  a_last_pixel_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |-> !back_status.busy)
    else $error("final pixel pending while a line is still in progress");

  // A step popped with no line in progress produces no pixel
  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop && queue_valid && queue_cmd.req == REQ_STEP && !back_status.busy
    |=> !out_valid_o)
    else $error("step without a line in progress produced a pixel");

endmodule

// File: hw/rtl/bls_front.sv
// Front end of the line stepper: classifies input beats and precomputes line setup.
// Depends on bls_pkg.
module bls_front
  import bls_pkg::*;
(
  input  in_item_t item_i,
  output cmd_t     cmd_o
);

  logic              dir_x_neg, dir_y_neg, x_major;
  logic [CoordW-1:0] adx, ady, maj, mnr;
  logic [DecW-1:0]   maj_e, mnr_e;

  // Direction signs and absolute deltas
  always_comb begin
    dir_x_neg = item_i.end_x < item_i.start_x;
    dir_y_neg = item_i.end_y < item_i.start_y;
    adx = dir_x_neg ? (item_i.start_x - item_i.end_x) : (item_i.end_x - item_i.start_x);
    ady = dir_y_neg ? (item_i.start_y - item_i.end_y) : (item_i.end_y - item_i.start_y);
    x_major = adx > ady;  // ties go to y
    maj = x_major ? adx : ady;
    mnr = x_major ? ady : adx;
    maj_e = {3'b000, maj};
    mnr_e = {3'b000, mnr};
  end

  // Command build: setup fields only matter for a start
  always_comb begin
    cmd_o.req          = item_i.req_type;
    cmd_o.dir_x_neg    = dir_x_neg;
    cmd_o.dir_y_neg    = dir_y_neg;
    cmd_o.x_major      = x_major;
    cmd_o.decision     = signed'({mnr_e[DecW-2:0], 1'b0} - maj_e);
    cmd_o.inc_diag     = signed'({mnr_e[DecW-2:0], 1'b0} - {maj_e[DecW-2:0], 1'b0});
    cmd_o.inc_straight = {1'b0, mnr, 1'b0};
    cmd_o.remaining    = maj;
    cmd_o.cur_x        = item_i.start_x;
    cmd_o.cur_y        = item_i.start_y;
  end

endmodule

// File: hw/rtl/bls_cmd_queue.sv
// Short command queue that decouples the line stepper's front and back ends.
// Depends on bls_pkg.
module bls_cmd_queue
  import bls_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = count_q == QueueCntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hw/rtl/bls_back.sv
// Back end of the line stepper: holds the line state, steps it, and drives the output register.
// Depends on bls_pkg.
module bls_back
  import bls_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cmd_valid_i,
  input  cmd_t         cmd_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_item_t    out_o,
  output back_status_t status_o
);

  logic [CoordW-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d, remaining_q, remaining_d;
  logic signed [DecW-1:0] decision_q, decision_d, inc_diag_q, inc_diag_d;
  logic [IncW-1:0]        inc_straight_q, inc_straight_d;
  logic                   dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic                   x_major_q, x_major_d, busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  logic                   can_take, emit;
  logic [CoordW-1:0]      rem_next, step_x, step_y;

  assign can_take    = !out_valid_q || !out_stall_i;
  assign pop_o       = cmd_valid_i && can_take;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign status_o.busy = busy_q;

  // Line state update and result build
  always_comb begin
    cur_x_d        = cur_x_q;
    cur_y_d        = cur_y_q;
    remaining_d    = remaining_q;
    decision_d     = decision_q;
    inc_diag_d     = inc_diag_q;
    inc_straight_d = inc_straight_q;
    dir_x_neg_d    = dir_x_neg_q;
    dir_y_neg_d    = dir_y_neg_q;
    x_major_d      = x_major_q;
    busy_d         = busy_q;
    emit           = 1'b0;
    rem_next       = remaining_q - 1'b1;
    step_x         = cur_x_q;
    step_y         = cur_y_q;
    out_d          = out_q;

    if (pop_o) begin
      unique case (cmd_i.req)
        REQ_START: begin
          cur_x_d        = cmd_i.cur_x;
          cur_y_d        = cmd_i.cur_y;
          remaining_d    = cmd_i.remaining;
          decision_d     = cmd_i.decision;
          inc_diag_d     = cmd_i.inc_diag;
          inc_straight_d = cmd_i.inc_straight;
          dir_x_neg_d    = cmd_i.dir_x_neg;
          dir_y_neg_d    = cmd_i.dir_y_neg;
          x_major_d      = cmd_i.x_major;
          busy_d         = cmd_i.remaining != '0;
          emit           = 1'b1;
        end
        REQ_STEP: begin
          // a step with no line in progress is dropped
          if (busy_q) begin
            if (!decision_q[DecW-1]) begin
              if (x_major_q) begin
                step_y = move_coord(cur_y_q, dir_y_neg_q);
              end else begin
                step_x = move_coord(cur_x_q, dir_x_neg_q);
              end
              decision_d = decision_q + inc_diag_q;
            end else begin
              decision_d = decision_q + signed'({1'b0, inc_straight_q});
            end
            if (x_major_q) begin
              step_x = move_coord(cur_x_q, dir_x_neg_q);
            end else begin
              step_y = move_coord(cur_y_q, dir_y_neg_q);
            end
            cur_x_d     = step_x;
            cur_y_d     = step_y;
            remaining_d = rem_next;
            busy_d      = rem_next != '0;
            emit        = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    if (emit) begin
      out_d.pixel_x = cur_x_d;
      out_d.pixel_y = cur_y_d;
      out_d.last    = remaining_d == '0;
    end
    out_valid_d = can_take ? emit : out_valid_q;
  end

  // Control and line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      remaining_q    <= '0;
      decision_q     <= '0;
      inc_diag_q     <= '0;
      inc_straight_q <= '0;
      dir_x_neg_q    <= 1'b0;
      dir_y_neg_q    <= 1'b0;
      x_major_q      <= 1'b0;
      busy_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      cur_x_q        <= cur_x_d;
      cur_y_q        <= cur_y_d;
      remaining_q    <= remaining_d;
      decision_q     <= decision_d;
      inc_diag_q     <= inc_diag_d;
      inc_straight_q <= inc_straight_d;
      dir_x_neg_q    <= dir_x_neg_d;
      dir_y_neg_q    <= dir_y_neg_d;
      x_major_q      <= x_major_d;
      busy_q         <= busy_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: verif/tb_top.sv
// Testbench for bresenham_line_stepper: directed and random lines checked pixel by pixel
// against a line predictor kept in the bench. Depends on bls_pkg and the block's RTL.

module tb_top;
  import bls_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int CoordMax  = 2**CoordW - 1;

  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_beat   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_beat;

  bresenham_line_stepper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_beat)
  );

  // Idle mix, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Run statistics
  int errors           = 0;
  int pixels_predicted = 0;
  int pixels_checked   = 0;
  int idle_steps       = 0;
  int lines_started    = 0;

  // Pixels still owed by the block, oldest first
  out_item_t expected_pixels[$];

  // Line state as the predictor sees it
  logic [CoordW-1:0]      ln_cur_x, ln_cur_y, ln_remaining;
  logic signed [DecW-1:0] ln_decision, ln_inc_diag;
  logic [IncW-1:0]        ln_inc_straight;
  logic                   ln_dir_x_neg, ln_dir_y_neg, ln_x_major, ln_busy;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Run limit, far past the slowest correct run
  initial begin
    #(ClkPeriod * 400000);
    $display("TEST FAILED");
    $finish;
  end

  // Advance the line by one accepted beat and queue the pixel it yields
  function automatic void predict_pixel(input in_item_t beat);
    logic [CoordW-1:0] adx, ady, maj, mnr;
    out_item_t px;
    if (beat.req_type == REQ_START) begin
      ln_dir_x_neg = beat.end_x < beat.start_x;
      ln_dir_y_neg = beat.end_y < beat.start_y;
      adx = ln_dir_x_neg ? beat.start_x - beat.end_x : beat.end_x - beat.start_x;
      ady = ln_dir_y_neg ? beat.start_y - beat.end_y : beat.end_y - beat.start_y;
      // ties go to the y axis
      ln_x_major = adx > ady;
      maj = ln_x_major ? adx : ady;
      mnr = ln_x_major ? ady : adx;
      ln_decision     = DecW'(2 * int'(mnr) - int'(maj));
      ln_inc_diag     = DecW'(2 * (int'(mnr) - int'(maj)));
      ln_inc_straight = IncW'(2 * int'(mnr));
      ln_remaining    = maj;
      ln_cur_x        = beat.start_x;
      ln_cur_y        = beat.start_y;
      ln_busy         = maj != '0;
      lines_started++;
    end else begin
      if (!ln_busy) begin
        idle_steps++;
        return;
      end
      // minor axis moves when the decision term is non-negative
      if (!ln_decision[DecW-1]) begin
        if (ln_x_major) ln_cur_y = ln_dir_y_neg ? ln_cur_y - 1'b1 : ln_cur_y + 1'b1;
        else            ln_cur_x = ln_dir_x_neg ? ln_cur_x - 1'b1 : ln_cur_x + 1'b1;
        ln_decision = ln_decision + ln_inc_diag;
      end else begin
        ln_decision = ln_decision + DecW'(ln_inc_straight);
      end
      if (ln_x_major) ln_cur_x = ln_dir_x_neg ? ln_cur_x - 1'b1 : ln_cur_x + 1'b1;
      else            ln_cur_y = ln_dir_y_neg ? ln_cur_y - 1'b1 : ln_cur_y + 1'b1;
      ln_remaining = ln_remaining - 1'b1;
      ln_busy      = ln_remaining != '0;
    end
    px.pixel_x = ln_cur_x;
    px.pixel_y = ln_cur_y;
    px.last    = ln_remaining == '0;
    expected_pixels.push_back(px);
    pixels_predicted++;
  endfunction

  function automatic logic [CoordW-1:0] rnd_coord();
    return CoordW'($urandom);
  endfunction

  // Coordinate within span of c, clamped to the range
  function automatic logic [CoordW-1:0] near_coord(input logic [CoordW-1:0] c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return CoordW'(v);
  endfunction

  // Send one beat, with random idle cycles ahead of it
  task automatic send_beat(input req_e req, input logic [CoordW-1:0] sx, sy, ex, ey);
    in_item_t beat;
    beat.req_type = req;
    beat.start_x  = sx;
    beat.start_y  = sy;
    beat.end_x    = ex;
    beat.end_y    = ey;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk_i); while (in_stall);
    predict_pixel(beat);
  endtask

  // Start a line and follow it with step beats carrying junk coordinates
  task automatic draw_line(input logic [CoordW-1:0] sx, sy, ex, ey, input int nsteps);
    send_beat(REQ_START, sx, sy, ex, ey);
    repeat (nsteps) send_beat(REQ_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
  endtask

  // Hold the sender off until every owed pixel has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Steps with no line in progress, and a single-point line
  task automatic test_idle_steps();
    send_idle_pct  = 20;
    recv_stall_pct = 40;
    send_beat(REQ_STEP, '1, '1, '1, '1);
    draw_line('0, '0, '0, '0, 1);
  endtask

  // Full-range diagonals, a restart mid-line and a restart while stalled
  task automatic test_full_range_restart();
    draw_line('1, '1, '0, '0, 2);
    draw_line('0, '1, '1, '0, 1);
    draw_line(12'd4095, 12'd0, 12'd0, 12'd1, 3);
  endtask

  // Short lines run to the end: horizontal, equal deltas, x-major backward
  task automatic test_short_lines();
    draw_line(12'd10, 12'd10, 12'd13, 12'd10, 4);
    draw_line(12'd100, 12'd100, 12'd97, 12'd103, 3);
    draw_line(12'd7, 12'd3, 12'd2, 12'd1, 5);
    wait_drained();
  endtask

  // Mostly whole lines with random endpoints; some aborted, some noise beats
  task automatic test_random_lines(input int idle_pct, input int stall_pct, input int n_target);
    int first, kind, span, nsteps, dx, dy, maj;
    logic [CoordW-1:0] sx, sy, ex, ey;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = pixels_predicted;
    while (pixels_predicted - first < n_target) begin
      kind = $urandom_range(99);
      sx = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : rnd_coord();
      sy = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : rnd_coord();
      if (kind < 10) begin
        send_beat(req_e'($urandom_range(1)), sx, sy, rnd_coord(), rnd_coord());
      end else begin
        if (kind < 25) begin
          ex = rnd_coord();
          ey = rnd_coord();
        end else begin
          span = $urandom_range(99);
          span = (span < 50) ? 8 : (span < 88) ? 40 : 300;
          ex = near_coord(sx, span);
          ey = near_coord(sy, span);
        end
        dx  = int'(ex) - int'(sx);
        dy  = int'(ey) - int'(sy);
        dx  = (dx < 0) ? -dx : dx;
        dy  = (dy < 0) ? -dy : dy;
        maj = (dx > dy) ? dx : dy;
        if (kind < 25)                    nsteps = $urandom_range(24);
        else if ($urandom_range(6) == 0) nsteps = $urandom_range(maj);
        else nsteps = maj + (($urandom_range(3) == 0) ? $urandom_range(2) : 0);
        draw_line(sx, sy, ex, ey, nsteps);
      end
    end
    wait_drained();
  endtask

  // Output side: random stall and compare each pixel beat with the oldest expectation
  always @(posedge clk_i) begin : pixel_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel beat: x %0d y %0d last %0b",
               out_beat.pixel_x, out_beat.pixel_y, out_beat.last);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_beat.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, actual %0d", want.pixel_x, out_beat.pixel_x);
          errors++;
        end
        if (out_beat.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, actual %0d", want.pixel_y, out_beat.pixel_y);
          errors++;
        end
        if (out_beat.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_beat.last);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Test sequence
  initial begin
    ln_cur_x = '0; ln_cur_y = '0; ln_remaining = '0;
    ln_decision = '0; ln_inc_diag = '0; ln_inc_straight = '0;
    ln_dir_x_neg = 1'b0; ln_dir_y_neg = 1'b0; ln_x_major = 1'b0; ln_busy = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_idle_steps();
    test_full_range_restart();
    test_short_lines();
    test_random_lines(16, 75, 560);
    test_random_lines(75, 16, 560);
    test_random_lines(0, 0, 560);
    if (expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", expected_pixels.size());
      errors++;
    end
    $display("Covered %0d lines, %0d pixels checked, %0d steps with no line in progress,",
             lines_started, pixels_checked, idle_steps);
    $display("under sender/receiver idle mixes 16/75, 75/16 and none.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
